FILE: rtl/lfu_cache_table_assert.svh
// Assertion macros for the LFU cache table.
// Used by lfu_cache_table.sv; expects clk_i and rst_ni in the including scope.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu_cache_table: assertion failed");

// Next-cycle implication, disabled during reset
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu_cache_table: assertion failed");

`endif

FILE: rtl/lfu_pkg.sv
// Shared types and constants of the LFU cache table.
// No dependencies; used by every module of the block.
`default_nettype none

package lfu_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation as classified by the front
  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_PUT     = 2'd1,
    OP_PUT_OFF = 2'd2   // put while capacity is zero: lookup only
  } lfu_op_e;

  typedef struct packed {
    lfu_op_e            op;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } lfu_item_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] level;
  } lfu_q_status_t;

  typedef enum logic [1:0] {
    BS_IDLE   = 2'd0,
    BS_SCAN   = 2'd1,
    BS_DRAIN  = 2'd2,
    BS_COMMIT = 2'd3
  } lfu_back_state_e;

endpackage

`default_nettype wire

FILE: rtl/lfu_queue.sv
// Small request FIFO between the front and the back of the LFU cache table.
// Depends on lfu_pkg for the item and status types.
`default_nettype none

module lfu_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  lfu_pkg::lfu_item_t   item_i,
  input  wire                  pop_i,
  output lfu_pkg::lfu_item_t   item_o,
  output lfu_pkg::lfu_q_status_t status_o
);

  lfu_pkg::lfu_item_t                  slot_q [lfu_pkg::QUEUE_DEPTH];
  logic [lfu_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lfu_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lfu_pkg::QUEUE_CNT_W-1:0]     level_q, level_d;
  logic                                do_push, do_pop;

  assign status_o.full  = (level_q == lfu_pkg::QUEUE_CNT_W'(lfu_pkg::QUEUE_DEPTH));
  assign status_o.empty = (level_q == '0);
  assign status_o.level = level_q;
  assign item_o         = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    do_push  = push_i && !status_o.full;
    do_pop   = pop_i && !status_o.empty;
    wr_ptr_d = do_push ? wr_ptr_q + lfu_pkg::QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + lfu_pkg::QUEUE_PTR_W'(1) : rd_ptr_q;
    level_d  = level_q;
    if (do_push && !do_pop) begin
      level_d = level_q + lfu_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - lfu_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lfu_front.sv
// Front of the LFU cache table: request handshake, capacity register, op classification.
// Depends on lfu_pkg; feeds lfu_queue.
`default_nettype none

module lfu_front #(
  parameter int CAPACITY = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire                            kind_i,
  input  wire  [lfu_pkg::KEY_W-1:0]      key_i,
  input  wire  [lfu_pkg::VAL_W-1:0]      value_i,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [lfu_pkg::CFG_W-1:0]      cfg_data_i,
  input  lfu_pkg::lfu_q_status_t         q_status_i,
  output logic                           push_o,
  output lfu_pkg::lfu_item_t             item_o,
  output logic [CNT_W-1:0]               cap_o
);

  logic [lfu_pkg::CFG_W-1:0] cap_reg_q;

  // capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg_q <= lfu_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_reg_q <= cfg_data_i;
    end
  end

  // values above the table size act as the table size
  always_comb begin
    if (32'(cap_reg_q) > CAPACITY) begin
      cap_o = CNT_W'(CAPACITY);
    end else begin
      cap_o = CNT_W'(cap_reg_q);
    end
  end

  // accept while the queue has room
  assign busy   = q_status_i.full;
  assign push_o = start && !busy;

  // classify the item
  always_comb begin
    item_o.key   = key_i;
    item_o.value = value_i;
    if (!kind_i) begin
      item_o.op = lfu_pkg::OP_GET;
    end else if (cap_o == '0) begin
      item_o.op = lfu_pkg::OP_PUT_OFF;
    end else begin
      item_o.op = lfu_pkg::OP_PUT;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lfu_back.sv
// Back of the LFU cache table: entry memory, serial key/victim scan, update and result.
// Depends on lfu_pkg; takes items from lfu_queue.
`default_nettype none

module lfu_back #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [CNT_W-1:0]               cap_i,
  input  lfu_pkg::lfu_q_status_t         q_status_i,
  input  lfu_pkg::lfu_item_t             q_item_i,
  output logic                           pop_o,
  output logic                           result_valid_o,
  output logic                           hit_o,
  output logic [lfu_pkg::VAL_W-1:0]      read_value_o,
  output logic                           evicted_o,
  output logic [lfu_pkg::KEY_W-1:0]      evicted_key_o,
  output logic [CNT_W-1:0]               held_o
);

  typedef struct packed {
    logic [lfu_pkg::KEY_W-1:0]   key;
    logic [lfu_pkg::VAL_W-1:0]   value;
    logic [COUNT_BITS-1:0]       cnt;
    logic [lfu_pkg::STAMP_W-1:0] stamp;
  } entry_t;

  // entry memory: valid entries always occupy slots below the fill count
  entry_t mem_q [CAPACITY];
  entry_t rd_word_q;
  logic   mem_we;
  logic [AW-1:0] mem_wr_addr;
  entry_t mem_wr_word;

  lfu_pkg::lfu_back_state_e state_q, state_d;
  lfu_pkg::lfu_item_t       item_q, item_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         held_q, held_d;
  logic [lfu_pkg::STAMP_W-1:0] use_clock_q, use_clock_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [AW-1:0]            rd_idx_q, rd_idx_d;

  // scan results
  logic                     hit_q, hit_d;
  logic [AW-1:0]            hit_slot_q, hit_slot_d;
  logic [lfu_pkg::VAL_W-1:0] hit_value_q, hit_value_d;
  logic [COUNT_BITS-1:0]    hit_cnt_q, hit_cnt_d;
  logic                     vic_vld_q, vic_vld_d;
  logic [AW-1:0]            vic_slot_q, vic_slot_d;
  logic [COUNT_BITS-1:0]    vic_cnt_q, vic_cnt_d;
  logic [lfu_pkg::STAMP_W-1:0] vic_age_q, vic_age_d;
  logic [lfu_pkg::KEY_W-1:0] vic_key_q, vic_key_d;

  // result registers
  logic                     res_valid_q, res_valid_d;
  logic                     res_hit_q, res_hit_d;
  logic [lfu_pkg::VAL_W-1:0] res_rd_q, res_rd_d;
  logic                     res_ev_q, res_ev_d;
  logic [lfu_pkg::KEY_W-1:0] res_evk_q, res_evk_d;

  logic [lfu_pkg::STAMP_W-1:0] rd_age;
  logic [lfu_pkg::STAMP_W-1:0] stamp_next;
  logic [COUNT_BITS-1:0]    cnt_inc;

  assign result_valid_o = res_valid_q;
  assign hit_o          = res_hit_q;
  assign read_value_o   = res_rd_q;
  assign evicted_o      = res_ev_q;
  assign evicted_key_o  = res_evk_q;
  assign held_o         = held_q;

  assign rd_age     = use_clock_q - rd_word_q.stamp;
  assign stamp_next = use_clock_q + lfu_pkg::STAMP_W'(1);
  assign cnt_inc    = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

  // sequencer: pop, scan held entries one per cycle, commit
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    held_d      = held_q;
    use_clock_d = use_clock_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_value_d = hit_value_q;
    hit_cnt_d   = hit_cnt_q;
    vic_vld_d   = vic_vld_q;
    vic_slot_d  = vic_slot_q;
    vic_cnt_d   = vic_cnt_q;
    vic_age_d   = vic_age_q;
    vic_key_d   = vic_key_q;
    res_valid_d = 1'b0;
    res_hit_d   = res_hit_q;
    res_rd_d    = res_rd_q;
    res_ev_d    = res_ev_q;
    res_evk_d   = res_evk_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = hit_slot_q;
    mem_wr_word = '{key: item_q.key, value: item_q.value, cnt: COUNT_BITS'(1),
                    stamp: stamp_next};

    // evaluate the entry read in the previous cycle
    if (rd_vld_q) begin
      if (rd_word_q.key == item_q.key) begin
        hit_d       = 1'b1;
        hit_slot_d  = rd_idx_q;
        hit_value_d = rd_word_q.value;
        hit_cnt_d   = rd_word_q.cnt;
      end
      // smallest count, then oldest use, first slot on a full tie
      if (!vic_vld_q || (rd_word_q.cnt < vic_cnt_q) ||
          ((rd_word_q.cnt == vic_cnt_q) && (rd_age > vic_age_q))) begin
        vic_vld_d  = 1'b1;
        vic_slot_d = rd_idx_q;
        vic_cnt_d  = rd_word_q.cnt;
        vic_age_d  = rd_age;
        vic_key_d  = rd_word_q.key;
      end
    end

    case (state_q)
      lfu_pkg::BS_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o     = 1'b1;
          item_d    = q_item_i;
          idx_d     = '0;
          hit_d     = 1'b0;
          vic_vld_d = 1'b0;
          state_d   = (held_q == '0) ? lfu_pkg::BS_COMMIT : lfu_pkg::BS_SCAN;
        end
      end
      lfu_pkg::BS_SCAN: begin
        rd_vld_d = 1'b1;
        rd_idx_d = idx_q[AW-1:0];
        idx_d    = idx_q + CNT_W'(1);
        if ((idx_q + CNT_W'(1)) == held_q) begin
          state_d = lfu_pkg::BS_DRAIN;
        end
      end
      lfu_pkg::BS_DRAIN: begin
        state_d = lfu_pkg::BS_COMMIT;
      end
      lfu_pkg::BS_COMMIT: begin
        res_valid_d = 1'b1;
        res_hit_d   = hit_q;
        res_rd_d    = '0;
        res_ev_d    = 1'b0;
        res_evk_d   = '0;
        state_d     = lfu_pkg::BS_IDLE;
        case (item_q.op)
          lfu_pkg::OP_GET: begin
            if (hit_q) begin
              res_rd_d    = hit_value_q;
              mem_we      = 1'b1;
              mem_wr_addr = hit_slot_q;
              mem_wr_word.value = hit_value_q;
              mem_wr_word.cnt   = cnt_inc;
              use_clock_d = stamp_next;
            end
          end
          lfu_pkg::OP_PUT: begin
            if (hit_q) begin
              mem_we      = 1'b1;
              mem_wr_addr = hit_slot_q;
              mem_wr_word.cnt = cnt_inc;
              use_clock_d = stamp_next;
            end else if (held_q < cap_i) begin
              // free slot at the end of the filled region
              mem_we      = 1'b1;
              mem_wr_addr = held_q[AW-1:0];
              held_d      = held_q + CNT_W'(1);
              use_clock_d = stamp_next;
            end else if (vic_vld_q) begin
              // replace the victim in place
              mem_we      = 1'b1;
              mem_wr_addr = vic_slot_q;
              res_ev_d    = 1'b1;
              res_evk_d   = vic_key_q;
              use_clock_d = stamp_next;
            end
          end
          default: begin
            // lookup only, no update
          end
        endcase
      end
      default: begin
        state_d = lfu_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::BS_IDLE;
      idx_q       <= '0;
      held_q      <= '0;
      use_clock_q <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      vic_vld_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      held_q      <= held_d;
      use_clock_q <= use_clock_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      vic_vld_q   <= vic_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    rd_idx_q    <= rd_idx_d;
    hit_slot_q  <= hit_slot_d;
    hit_value_q <= hit_value_d;
    hit_cnt_q   <= hit_cnt_d;
    vic_slot_q  <= vic_slot_d;
    vic_cnt_q   <= vic_cnt_d;
    vic_age_q   <= vic_age_d;
    vic_key_q   <= vic_key_d;
    res_hit_q   <= res_hit_d;
    res_rd_q    <= res_rd_d;
    res_ev_q    <= res_ev_d;
    res_evk_q   <= res_evk_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wr_addr] <= mem_wr_word;
    end
    rd_word_q <= mem_q[idx_q[AW-1:0]];
  end

endmodule

`default_nettype wire

FILE: rtl/lfu_cache_table.sv
// Top level of the LFU cache table: front, request queue and back.
// Depends on lfu_pkg, lfu_front, lfu_queue, lfu_back and lfu_cache_table_assert.svh.
//
// Usage:
//   Requests: drive kind_i (0 get, 1 put), key_i, value_i with start; an item
//   is taken at a clock edge where start is high and busy is low. busy rises
//   only while the two-entry request queue is full.
//   Results: one per item, in order, held for exactly one cycle while
//   result_valid_o is high: hit_o, read_value_o, evicted_o, evicted_key_o.
//   The receiver cannot stall; results must be captured when presented.
//   Configuration: cfg_data_i written on cfg_valid_i (cfg_ready_o is always
//   high); capacity in use, values above CAPACITY act as CAPACITY, zero turns
//   puts into lookups. Write it only while no item is outstanding.
//   Timing: the back reads the entry memory one slot per cycle through its
//   single read port; each item is popped in idle, scanned against the N
//   entries held and drained (both skipped when empty), then committed; its
//   result is registered, and the next item is popped once back in idle.
//   Reset: the cache is empty, the use clock is zero and the capacity is 16;
//   no clearing pass is needed since the fill count marks the valid slots.
`default_nettype none
`include "lfu_cache_table_assert.svh"

module lfu_cache_table #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          kind_i,
  input  wire  [lfu_pkg::KEY_W-1:0]    key_i,
  input  wire  [lfu_pkg::VAL_W-1:0]    value_i,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [lfu_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                         result_valid_o,
  output logic                         hit_o,
  output logic [lfu_pkg::VAL_W-1:0]    read_value_o,
  output logic                         evicted_o,
  output logic [lfu_pkg::KEY_W-1:0]    evicted_key_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  lfu_pkg::lfu_q_status_t q_status;
  lfu_pkg::lfu_item_t     push_item;
  lfu_pkg::lfu_item_t     pop_item;
  logic                   push;
  logic                   pop;
  logic [CNT_W-1:0]       cap;
  logic [CNT_W-1:0]       held;

  lfu_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .item_o      (push_item),
    .cap_o       (cap)
  );

  lfu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  lfu_back #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cap_i          (cap),
    .q_status_i     (q_status),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .held_o         (held)
  );

  // an eviction only happens on a put miss
  `LFU_ASSERT_IMPL(a_evict_on_miss, result_valid_o && evicted_o, !hit_o)
  // a returned value means the key was present
  `LFU_ASSERT_IMPL(a_value_on_hit, result_valid_o && (read_value_o != '0), hit_o)
  // the fill count never passes the table size
  `LFU_ASSERT_IMPL(a_held_bound, 1'b1, held <= CNT_W'(CAPACITY))
  // commit always returns to idle, so results never come in consecutive cycles
  `LFU_ASSERT_NEXT(a_result_gap, result_valid_o, !result_valid_o)

endmodule

`default_nettype wire

FILE: tb/lfu_cache_checker.sv
`timescale 1ns / 100ps
// Result checker for the LFU cache table: follows the request, result and
// capacity channels, keeps its own copy of the cache and compares every result.
// Depends on lfu_pkg.
module lfu_cache_checker #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire                       busy_i,
  input  wire                       kind_i,
  input  wire [lfu_pkg::KEY_W-1:0]  key_i,
  input  wire [lfu_pkg::VAL_W-1:0]  value_i,
  input  wire                       cfg_valid_i,
  input  wire                       cfg_ready_i,
  input  wire [lfu_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire                       res_valid_i,
  input  wire                       hit_i,
  input  wire [lfu_pkg::VAL_W-1:0]  read_value_i,
  input  wire                       evicted_i,
  input  wire [lfu_pkg::KEY_W-1:0]  evicted_key_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::KEY_W-1:0] evicted_key;
  } lookup_result_t;

  // Shadow copy of the cache
  logic                        slot_used  [CAPACITY];
  logic [lfu_pkg::KEY_W-1:0]   slot_key   [CAPACITY];
  logic [lfu_pkg::VAL_W-1:0]   slot_value [CAPACITY];
  logic [COUNT_BITS-1:0]       slot_count [CAPACITY];
  logic [lfu_pkg::STAMP_W-1:0] slot_stamp [CAPACITY];
  logic [lfu_pkg::STAMP_W-1:0] stamp_now;
  int                          fill;
  logic [lfu_pkg::CFG_W-1:0]   capacity;

  lookup_result_t owed_results[$];
  int             mismatches = 0;

  // Hit on a slot: saturating count, fresh stamp
  function automatic void touch_slot(int s);
    if (slot_count[s] != '1) slot_count[s] = slot_count[s] + 1'b1;
    stamp_now     = stamp_now + 1'b1;
    slot_stamp[s] = stamp_now;
  endfunction

  // Applies one request to the shadow cache and returns what the block must report
  function automatic lookup_result_t serve_request(lfu_pkg::lfu_op_e op,
                                                   logic [lfu_pkg::KEY_W-1:0] key,
                                                   logic [lfu_pkg::VAL_W-1:0] value);
    lookup_result_t              r;
    int                          eff_cap;
    int                          found;
    int                          victim;
    int                          dst;
    int                          s;
    logic [lfu_pkg::STAMP_W-1:0] age;
    logic [lfu_pkg::STAMP_W-1:0] best_age;
    r        = '0;
    eff_cap  = (capacity > CAPACITY) ? CAPACITY : int'(capacity);
    found    = -1;
    victim   = -1;
    dst      = -1;
    best_age = '0;
    for (s = 0; s < CAPACITY; s++) begin
      if (found < 0 && slot_used[s] && slot_key[s] == key) found = s;
    end
    r.hit = (found >= 0);

    if (op == lfu_pkg::OP_GET) begin
      if (found >= 0) begin
        r.read_value = slot_value[found];
        touch_slot(found);
      end
    end else if (eff_cap != 0) begin
      if (found >= 0) begin
        slot_value[found] = value;
        touch_slot(found);
      end else begin
        // full (or over a lowered capacity): drop lowest count, oldest on ties
        if (fill >= eff_cap) begin
          for (s = 0; s < CAPACITY; s++) begin
            if (slot_used[s]) begin
              age = stamp_now - slot_stamp[s];
              if (victim < 0 || slot_count[s] < slot_count[victim] ||
                  (slot_count[s] == slot_count[victim] && age > best_age)) begin
                victim   = s;
                best_age = age;
              end
            end
          end
          if (victim >= 0) begin
            r.evicted         = 1'b1;
            r.evicted_key     = slot_key[victim];
            slot_used[victim] = 1'b0;
            fill--;
          end
        end
        for (s = 0; s < CAPACITY; s++) begin
          if (dst < 0 && !slot_used[s]) dst = s;
        end
        if (dst >= 0) begin
          stamp_now       = stamp_now + 1'b1;
          slot_used[dst]  = 1'b1;
          slot_key[dst]   = key;
          slot_value[dst] = value;
          slot_count[dst] = COUNT_BITS'(1);
          slot_stamp[dst] = stamp_now;
          fill++;
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  // Sample mid-cycle: everything seen here holds at the next rising edge
  always @(negedge clk_i) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < CAPACITY; s++) slot_used[s] = 1'b0;
      stamp_now = '0;
      fill      = 0;
      capacity  = lfu_pkg::CFG_RESET;
      owed_results.delete();
    end else begin
      if ($isunknown(res_valid_i)) begin
        mismatches++;
        $display("%0t: result strobe expected 0/1 actual %b", $time, res_valid_i);
      end else if (res_valid_i) begin
        // a result always belongs to an item taken at an earlier edge
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual hit %b value %h evicted %b key %h",
                   $time, hit_i, read_value_i, evicted_i, evicted_key_i);
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          compare_field("hit", 32'(want.hit), 32'(hit_i));
          compare_field("read_value", want.read_value, read_value_i);
          compare_field("evicted", 32'(want.evicted), 32'(evicted_i));
          compare_field("evicted_key", want.evicted_key, evicted_key_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (start_i && !busy_i) begin
        owed_results.push_back(serve_request(lfu_pkg::lfu_op_e'({1'b0, kind_i}),
                                             key_i, value_i));
      end
    end
    pending_o    = owed_results.size();
    fail_count_o = mismatches;
  end

endmodule

FILE: tb/tb_lfu_cache_table.sv
`timescale 1ns / 100ps
// Testbench top for the LFU cache table: clock, reset, request and capacity
// stimulus, and the verdict. Depends on lfu_pkg, lfu_cache_table and
// lfu_cache_checker.
module tb_lfu_cache_table;

  localparam int CAPACITY     = 16;
  localparam int COUNT_BITS   = 16;
  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASES       = 8;
  localparam int KEY_POOL     = 24;
  localparam int CYCLE_LIMIT  = 300000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      kind_i      = 1'b0;
  logic [lfu_pkg::KEY_W-1:0] key_i       = '0;
  logic [lfu_pkg::VAL_W-1:0] value_i     = '0;
  logic                      cfg_valid_i = 1'b0;
  logic [lfu_pkg::CFG_W-1:0] cfg_data_i  = '0;

  wire                       busy;
  wire                       cfg_ready_o;
  wire                       result_valid_o;
  wire                       hit_o;
  wire [lfu_pkg::VAL_W-1:0]  read_value_o;
  wire                       evicted_o;
  wire [lfu_pkg::KEY_W-1:0]  evicted_key_o;

  int                        fail_count;
  int                        pending;
  int                        cycles = 0;
  bit                        tight  = 1'b0;
  logic [lfu_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  always #HALF_PERIOD clk_i = ~clk_i;

  lfu_cache_table #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o)
  );

  lfu_cache_checker #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_valid_i   (result_valid_o),
    .hit_i         (hit_o),
    .read_value_i  (read_value_o),
    .evicted_i     (evicted_o),
    .evicted_key_i (evicted_key_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Present one item after a random gap (none in tight mode) and hold it until taken.
  // Called right after a rising edge; returns right after the taking edge.
  task automatic send_item(lfu_pkg::lfu_op_e op, logic [lfu_pkg::KEY_W-1:0] key,
                           logic [lfu_pkg::VAL_W-1:0] value);
    int gap;
    bit taken;
    gap = tight ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= op[0];
    key_i   <= key;
    value_i <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (busy === 1'b0);
      @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Capacity is only written with nothing outstanding
  task automatic write_capacity(logic [lfu_pkg::CFG_W-1:0] cap);
    bit taken;
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (cfg_ready_o === 1'b1);
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly keys from a small pool so hits and evictions happen; a few hot keys
  function automatic logic [lfu_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 2) == 0) return key_pool[$urandom_range(0, 3)];
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [lfu_pkg::CFG_W-1:0] phase_caps [PHASES];
    lfu_pkg::lfu_op_e          op;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    phase_caps = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd3, 5'd16, 5'd8};
    phase_caps[PHASES-1] = lfu_pkg::CFG_W'($urandom_range(0, 31));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two-entry cache: misses, updates, count order and age tie-break
    write_capacity(5'd2);
    send_item(lfu_pkg::OP_GET, 32'h0, 32'h0);               // miss on empty cache
    send_item(lfu_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send_item(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);       // now full
    send_item(lfu_pkg::OP_GET, 32'h0, 32'h5555_5555);       // hit, count 2
    send_item(lfu_pkg::OP_PUT, 32'h0, 32'h1234_5678);       // put hit, count 3
    send_item(lfu_pkg::OP_PUT, 32'h5, 32'h1);               // evicts the low-count key
    send_item(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);       // gone
    send_item(lfu_pkg::OP_PUT, 32'h6, 32'hAAAA_AAAA);       // evicts key 5
    send_item(lfu_pkg::OP_GET, 32'h6, 32'h0);
    send_item(lfu_pkg::OP_GET, 32'h6, 32'h0);               // count tie with key 0
    send_item(lfu_pkg::OP_PUT, 32'h7, 32'h7);               // tie: older key 0 goes

    // Zero capacity: puts only look up
    write_capacity(5'd0);
    send_item(lfu_pkg::OP_PUT, 32'h6, 32'h0BAD_0BAD);       // hit reported, no write
    send_item(lfu_pkg::OP_PUT, 32'h8, 32'h8);               // no insert
    send_item(lfu_pkg::OP_GET, 32'h6, 32'h0);
    send_item(lfu_pkg::OP_GET, 32'h8, 32'h0);

    // Register above the table size acts as the table size
    write_capacity(5'd31);
    send_item(lfu_pkg::OP_PUT, 32'h9, 32'h9);
    send_item(lfu_pkg::OP_PUT, 32'hA, 32'hA);
    send_item(lfu_pkg::OP_PUT, 32'hB, 32'hB);
    send_item(lfu_pkg::OP_PUT, 32'hC, 32'hC);

    // Capacity below the fill: one eviction per insert, fill unchanged
    write_capacity(5'd1);
    send_item(lfu_pkg::OP_PUT, 32'hD, 32'hD);
    send_item(lfu_pkg::OP_GET, 32'hD, 32'h0);
    send_item(lfu_pkg::OP_PUT, 32'hE, 32'hE);

    // Random phases, each under its own capacity
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 32 == 0) tight = ($urandom_range(0, 3) == 0);
        if (n == RANDOM_ITEMS / (2 * PHASES)) drain_results();
        op = $urandom_range(0, 1) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
        send_item(op, pick_key(), $urandom);
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
